// ----- rtl/core/udptx_pkg.sv -----
// Shared types and constants for the UDP transmit header and checksum unit.
package udptx_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned TOTAL_W  = COUNT_W + 1;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [TOTAL_W-1:0] UDP_HDR_LEN = TOTAL_W'(8);
  localparam logic [WORD_W-1:0]  PROTO_UDP   = WORD_W'(17);
  localparam logic [WORD_W-1:0]  CSUM_ZERO   = 16'hFFFF;

  // register index lives above the byte offset within the word
  localparam logic REG_LOCAL_IP = 1'b0;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // one closed datagram, handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0]  sum;
    logic               odd;
    logic [DATA_W-1:0]  held;
    logic [TOTAL_W-1:0] total;
    logic               too_long;
    logic [IP_W-1:0]    dest_ip;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/core/udptx_front.sv -----
// Front end: takes payload bytes, keeps the running ones'-complement sum and closes datagrams.
module udptx_front #(
  parameter int unsigned MAX_DATAGRAM = 1500
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [udptx_pkg::DATA_W-1:0] data_byte_i,
  input  logic                         has_byte_i,
  input  logic                         last_byte_i,
  input  logic [udptx_pkg::IP_W-1:0]   dest_ip_i,
  input  logic [udptx_pkg::PORT_W-1:0] sport_i,
  input  logic [udptx_pkg::PORT_W-1:0] dport_i,
  input  udptx_pkg::fifo_stat_t        fifo_stat_i,
  output logic                         push_o,
  output udptx_pkg::rec_t              rec_o
);
  import udptx_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_DATAGRAM);
  localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(MAX_DATAGRAM);

  logic [WORD_W-1:0]  sum_q, sum_d;
  logic               odd_q, odd_d;
  logic [DATA_W-1:0]  held_q, held_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [WORD_W:0]    raw_sum;
  logic [TOTAL_W-1:0] total;
  logic               accept;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign raw_sum    = {1'b0, sum_q} + {1'b0, held_q, data_byte_i};

  always_comb begin
    sum_d   = sum_q;
    odd_d   = odd_q;
    held_d  = held_q;
    count_d = count_q;
    if (has_byte_i) begin
      if (odd_q) begin
        // end-around carry
        sum_d  = raw_sum[WORD_W-1:0] + WORD_W'(raw_sum[WORD_W]);
        odd_d  = 1'b0;
        held_d = '0;
      end else begin
        held_d = data_byte_i;
        odd_d  = 1'b1;
      end
      if (count_q < MaxCount) count_d = count_q + COUNT_W'(1);
    end
  end

  assign total = {1'b0, count_d} + UDP_HDR_LEN;

  assign push_o         = accept && last_byte_i;
  assign rec_o.sum      = sum_d;
  assign rec_o.odd      = odd_d;
  assign rec_o.held     = held_d;
  assign rec_o.total    = total;
  assign rec_o.too_long = total > MaxTotal;
  assign rec_o.dest_ip  = dest_ip_i;
  assign rec_o.sport    = sport_i;
  assign rec_o.dport    = dport_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      odd_q   <= 1'b0;
      held_q  <= '0;
      count_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        sum_q   <= '0;
        odd_q   <= 1'b0;
        held_q  <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        odd_q   <= odd_d;
        held_q  <= held_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// ----- rtl/core/udptx_fifo.sv -----
// Short queue of closed datagrams between front and back.
module udptx_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  udptx_pkg::rec_t       rec_i,
  input  logic                  pop_i,
  output udptx_pkg::rec_t       rec_o,
  output udptx_pkg::fifo_stat_t stat_o
);
  import udptx_pkg::*;

  localparam logic [FIFO_PTR_W-1:0] LastPtr = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] Depth   = FIFO_CNT_W'(FIFO_DEPTH);

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign stat_o.full  = cnt_q == Depth;
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/udptx_back.sv -----
// Back end: adds pseudo-header and header words, folds, complements and holds the result.
module udptx_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [udptx_pkg::IP_W-1:0]    local_ip_i,
  input  udptx_pkg::fifo_stat_t         fifo_stat_i,
  input  udptx_pkg::rec_t               rec_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [udptx_pkg::PORT_W-1:0]  out_sport_o,
  output logic [udptx_pkg::PORT_W-1:0]  out_dport_o,
  output logic [udptx_pkg::COUNT_W-1:0] dgram_len_o,
  output logic [udptx_pkg::WORD_W-1:0]  checksum_o,
  output logic [udptx_pkg::IP_W-1:0]    out_dest_ip_o,
  output logic                          status_o
);
  import udptx_pkg::*;

  localparam int unsigned PART_W = WORD_W + 3;
  localparam int unsigned ACC_W  = WORD_W + 4;

  // stage one: two partial sums
  logic               s1_valid_q;
  logic [PART_W-1:0]  s1_a_q, s1_b_q, part_a, part_b;
  logic [TOTAL_W-1:0] s1_total_q;
  logic               s1_too_long_q;
  logic [IP_W-1:0]    s1_dip_q;
  logic [PORT_W-1:0]  s1_sport_q, s1_dport_q;
  logic               s1_en, out_en;

  logic [WORD_W-1:0]  pad_word;
  logic [ACC_W-1:0]   acc;
  logic [WORD_W:0]    fold1;
  logic [WORD_W-1:0]  fold2, csum;

  logic               out_valid_q;
  logic [PORT_W-1:0]  sport_q, dport_q;
  logic [COUNT_W-1:0] len_q;
  logic [WORD_W-1:0]  csum_q;
  logic [IP_W-1:0]    dip_q;
  logic               status_q;

  assign out_en = !out_valid_q || out_ready_i;
  assign s1_en  = !s1_valid_q || out_en;
  assign pop_o  = s1_en && !fifo_stat_i.empty;

  assign pad_word = rec_i.odd ? {rec_i.held, 8'h00} : '0;

  assign part_a = PART_W'(rec_i.sum) + PART_W'(pad_word)
                + PART_W'(local_ip_i[IP_W-1:WORD_W]) + PART_W'(local_ip_i[WORD_W-1:0]);
  // length counted twice: pseudo-header and header
  assign part_b = PART_W'(rec_i.dest_ip[IP_W-1:WORD_W]) + PART_W'(rec_i.dest_ip[WORD_W-1:0])
                + PART_W'(rec_i.sport) + PART_W'(rec_i.dport)
                + PART_W'({rec_i.total, 1'b0}) + PART_W'(PROTO_UDP);

  always_ff @(posedge clk_i) begin
    if (s1_en && pop_o) begin
      s1_a_q        <= part_a;
      s1_b_q        <= part_b;
      s1_total_q    <= rec_i.total;
      s1_too_long_q <= rec_i.too_long;
      s1_dip_q      <= rec_i.dest_ip;
      s1_sport_q    <= rec_i.sport;
      s1_dport_q    <= rec_i.dport;
    end
  end

  // stage two: add, fold twice, complement
  assign acc   = ACC_W'(s1_a_q) + ACC_W'(s1_b_q);
  assign fold1 = {1'b0, acc[WORD_W-1:0]} + (WORD_W+1)'(acc[ACC_W-1:WORD_W]);
  assign fold2 = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);
  assign csum  = (~fold2 == '0) ? CSUM_ZERO : ~fold2;

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      if (s1_too_long_q) begin
        sport_q  <= '0;
        dport_q  <= '0;
        len_q    <= '0;
        csum_q   <= '0;
        dip_q    <= '0;
        status_q <= STATUS_TOO_LONG;
      end else begin
        sport_q  <= s1_sport_q;
        dport_q  <= s1_dport_q;
        len_q    <= s1_total_q[COUNT_W-1:0];
        csum_q   <= csum;
        dip_q    <= s1_dip_q;
        status_q <= STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= !fifo_stat_i.empty;
      if (out_en) out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sport_o   = sport_q;
  assign out_dport_o   = dport_q;
  assign dgram_len_o   = len_q;
  assign checksum_o    = csum_q;
  assign out_dest_ip_o = dip_q;
  assign status_o      = status_q;

endmodule

// ----- rtl/core/udp_tx_header_checksum_unit.sv -----
// Top level of the UDP transmit header and checksum unit, with its register port.
//
//   channel   direction  handshake            carries
//   input     in         in_valid_i/ready_o   one payload byte, flags, address and ports
//   output    out        out_valid_o/ready_i  one header word per datagram
//   config    in         APB psel/penable     local_ip at byte address 0
//
// One input byte per cycle while in_ready_o is high; the running sum uses one end-around-carry add per byte pair.
// A datagram's header word is registered through the queue write, then two back stages, and datagrams
// stream back to back while out_ready_i is high.
// Reset clears the sum, counters, queue and local_ip; no clearing pass.
// in_ready_o drops only when the two-entry queue of closed datagrams is full.
module udp_tx_header_checksum_unit #(
  parameter int unsigned MAX_DATAGRAM = 1500
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [udptx_pkg::PADDR_W-1:0]     paddr,
  input  logic [udptx_pkg::APB_DW-1:0]      pwdata,
  output logic [udptx_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [udptx_pkg::DATA_W-1:0]      data_byte_i,
  input  logic                              has_byte_i,
  input  logic                              last_byte_i,
  input  logic [udptx_pkg::IP_W-1:0]        dest_ip_i,
  input  logic [udptx_pkg::PORT_W-1:0]      sport_i,
  input  logic [udptx_pkg::PORT_W-1:0]      dport_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [udptx_pkg::PORT_W-1:0]      out_sport_o,
  output logic [udptx_pkg::PORT_W-1:0]      out_dport_o,
  output logic [udptx_pkg::COUNT_W-1:0]     dgram_len_o,
  output logic [udptx_pkg::WORD_W-1:0]      checksum_o,
  output logic [udptx_pkg::IP_W-1:0]        out_dest_ip_o,
  output logic                              status_o
);
  import udptx_pkg::*;

  logic [IP_W-1:0] local_ip_q;
  logic            reg_sel;
  logic            push, pop;
  rec_t            push_rec, pop_rec;
  fifo_stat_t      fifo_stat;

  // register index sits above the two byte-offset bits
  assign reg_sel = paddr[PADDR_W-1] == REG_LOCAL_IP;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? local_ip_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      local_ip_q <= pwdata;
    end
  end

  udptx_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_byte_i (last_byte_i),
    .dest_ip_i   (dest_ip_i),
    .sport_i     (sport_i),
    .dport_i     (dport_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  udptx_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (pop_rec),
    .stat_o (fifo_stat)
  );

  udptx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .local_ip_i    (local_ip_q),
    .fifo_stat_i   (fifo_stat),
    .rec_i         (pop_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_sport_o   (out_sport_o),
    .out_dport_o   (out_dport_o),
    .dgram_len_o   (dgram_len_o),
    .checksum_o    (checksum_o),
    .out_dest_ip_o (out_dest_ip_o),
    .status_o      (status_o)
  );

endmodule
